[sv/ultrasonic_echo_ranger_top_assert.svh]
// Assertion macros for the echo ranger.
`ifndef ULTRASONIC_ECHO_RANGER_TOP_ASSERT_SVH
`define ULTRASONIC_ECHO_RANGER_TOP_ASSERT_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define UER_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("uer: same-cycle check failed");

// Next-cycle implication, checked at every rising edge out of reset.
`define UER_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("uer: next-cycle check failed");

`endif

[sv/uer_pkg.sv]
`timescale 1ns / 1ps
package uer_pkg;

  localparam int unsigned TICK_W = 16;
  localparam int unsigned WRAP_W = 9;
  localparam int unsigned MAXW_W = 8;
  localparam int unsigned DIST_W = 16;
  localparam int unsigned REM_W  = 14;
  localparam int unsigned IDX_W  = 2;
  localparam int unsigned CFG_W  = 16;

  // Register indexes on the configuration port.
  localparam logic [IDX_W-1:0] REG_PULSE_TICKS  = 2'd0;
  localparam logic [IDX_W-1:0] REG_PERIOD_TICKS = 2'd1;
  localparam logic [IDX_W-1:0] REG_MAX_WRAPS    = 2'd2;
  localparam logic [IDX_W-1:0] REG_OOR_CM       = 2'd3;

  localparam logic [TICK_W-1:0] PULSE_RST  = 16'd100;
  localparam logic [TICK_W-1:0] PERIOD_RST = 16'd60000;
  localparam logic [MAXW_W-1:0] MAXW_RST   = 8'd3;
  localparam logic [DIST_W-1:0] OOR_RST    = 16'd400;

  // Distance is ticks * 17 / 10000 cm.
  localparam logic [REM_W-1:0]  CM_MUL   = 14'd17;
  localparam logic [REM_W-1:0]  CM_DIV   = 14'd10000;
  localparam logic [WRAP_W-1:0] WRAP_MAX = 9'd511;
  localparam logic [DIST_W-1:0] DIST_MAX = 16'hFFFF;

  typedef struct packed {
    logic pulse_step;
    logic count;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic pulse_last;
  } dp_stat_t;

endpackage

[sv/uer_dp.sv]
`timescale 1ns / 1ps
module uer_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [uer_pkg::IDX_W-1:0]     cfg_index,
  input  logic [uer_pkg::CFG_W-1:0]     cfg_data,
  input  uer_pkg::dp_cmd_t              cmd,
  output uer_pkg::dp_stat_t             stat,
  output logic [uer_pkg::DIST_W-1:0]    last_dist
);

  logic [uer_pkg::TICK_W-1:0] pulse_r;
  logic [uer_pkg::TICK_W-1:0] period_r;
  logic [uer_pkg::MAXW_W-1:0] maxw_r;
  logic [uer_pkg::DIST_W-1:0] oor_r;

  logic [uer_pkg::TICK_W-1:0] tick_r, tick_nxt;
  logic [uer_pkg::WRAP_W-1:0] wrap_r, wrap_nxt;
  logic [uer_pkg::DIST_W-1:0] cm_r, cm_nxt;
  logic [uer_pkg::REM_W-1:0]  rem_r, rem_nxt;
  logic [uer_pkg::DIST_W-1:0] last_r, last_nxt;

  logic [uer_pkg::TICK_W:0]   tick_inc;
  logic [uer_pkg::REM_W-1:0]  rem_add;
  logic [uer_pkg::DIST_W-1:0] dist_sel;

  assign tick_inc = {1'b0, tick_r} + {{uer_pkg::TICK_W{1'b0}}, 1'b1};
  assign stat.pulse_last = (tick_inc >= {1'b0, pulse_r});
  assign rem_add = rem_r + uer_pkg::CM_MUL;
  assign last_dist = last_r;

  // Every echo tick adds one to the total wraps*period + count, so the
  // centimetre figure is kept as a running quotient and remainder.
  always_comb begin
    if (wrap_r > {1'b0, maxw_r}) begin
      dist_sel = oor_r;
    end else if (period_r == '0) begin
      dist_sel = '0;
    end else begin
      dist_sel = cm_r;
    end
  end

  always_comb begin
    tick_nxt = tick_r;
    wrap_nxt = wrap_r;
    cm_nxt   = cm_r;
    rem_nxt  = rem_r;
    last_nxt = last_r;
    if (cmd.pulse_step) begin
      tick_nxt = stat.pulse_last ? '0 : tick_inc[uer_pkg::TICK_W-1:0];
    end
    if (cmd.count) begin
      if (tick_inc >= {1'b0, period_r}) begin
        tick_nxt = '0;
        if (wrap_r != uer_pkg::WRAP_MAX) begin
          wrap_nxt = wrap_r + {{(uer_pkg::WRAP_W-1){1'b0}}, 1'b1};
        end
      end else begin
        tick_nxt = tick_inc[uer_pkg::TICK_W-1:0];
      end
      if (rem_add >= uer_pkg::CM_DIV) begin
        rem_nxt = rem_add - uer_pkg::CM_DIV;
        if (cm_r != uer_pkg::DIST_MAX) begin
          cm_nxt = cm_r + {{(uer_pkg::DIST_W-1){1'b0}}, 1'b1};
        end
      end else begin
        rem_nxt = rem_add;
      end
    end
    if (cmd.finish) begin
      last_nxt = dist_sel;
      tick_nxt = '0;
      wrap_nxt = '0;
      cm_nxt   = '0;
      rem_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_r  <= uer_pkg::PULSE_RST;
      period_r <= uer_pkg::PERIOD_RST;
      maxw_r   <= uer_pkg::MAXW_RST;
      oor_r    <= uer_pkg::OOR_RST;
      tick_r   <= '0;
      wrap_r   <= '0;
      cm_r     <= '0;
      rem_r    <= '0;
      last_r   <= '0;
    end else begin
      tick_r <= tick_nxt;
      wrap_r <= wrap_nxt;
      cm_r   <= cm_nxt;
      rem_r  <= rem_nxt;
      last_r <= last_nxt;
      if (cfg_we) begin
        case (cfg_index)
          uer_pkg::REG_PULSE_TICKS:  pulse_r  <= cfg_data;
          uer_pkg::REG_PERIOD_TICKS: period_r <= cfg_data;
          uer_pkg::REG_MAX_WRAPS:    maxw_r   <= cfg_data[uer_pkg::MAXW_W-1:0];
          uer_pkg::REG_OOR_CM:       oor_r    <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

[sv/uer_ctrl.sv]
`timescale 1ns / 1ps
module uer_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              start_req,
  input  logic              echo_level,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic              trig_out,
  output logic              busy_out,
  output logic              done_out,
  input  uer_pkg::dp_stat_t stat,
  output uer_pkg::dp_cmd_t  cmd
);

  typedef enum logic [1:0] {PH_IDLE, PH_TRIG, PH_WAIT, PH_MEAS} phase_t;

  phase_t           phase_r, phase_nxt;
  logic             valid_r;
  logic             trig_r, busy_r, done_r;
  logic             trig_nxt, done_nxt;
  logic             step;
  uer_pkg::dp_cmd_t cmd_nxt;

  assign in_tready  = !valid_r || out_tready;
  assign step       = in_tvalid && in_tready;
  assign out_tvalid = valid_r;
  assign trig_out   = trig_r;
  assign busy_out   = busy_r;
  assign done_out   = done_r;
  assign cmd        = step ? cmd_nxt : '0;

  always_comb begin
    phase_nxt = phase_r;
    trig_nxt  = 1'b0;
    done_nxt  = 1'b0;
    cmd_nxt   = '0;
    case (phase_r)
      PH_IDLE: begin
        if (start_req) begin
          trig_nxt           = 1'b1;
          cmd_nxt.pulse_step = 1'b1;
          phase_nxt          = stat.pulse_last ? PH_WAIT : PH_TRIG;
        end
      end
      PH_TRIG: begin
        trig_nxt           = 1'b1;
        cmd_nxt.pulse_step = 1'b1;
        if (stat.pulse_last) begin
          phase_nxt = PH_WAIT;
        end
      end
      PH_WAIT: begin
        if (echo_level) begin
          cmd_nxt.count = 1'b1;
          phase_nxt     = PH_MEAS;
        end
      end
      PH_MEAS: begin
        if (echo_level) begin
          cmd_nxt.count = 1'b1;
        end else begin
          cmd_nxt.finish = 1'b1;
          done_nxt       = 1'b1;
          phase_nxt      = PH_IDLE;
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      valid_r <= 1'b0;
      trig_r  <= 1'b0;
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      if (step) begin
        phase_r <= phase_nxt;
        valid_r <= 1'b1;
        trig_r  <= trig_nxt;
        busy_r  <= (phase_nxt != PH_IDLE);
        done_r  <= done_nxt;
      end else if (out_tready) begin
        valid_r <= 1'b0;
      end
    end
  end

endmodule

[sv/ultrasonic_echo_ranger_top.sv]
// A result item is registered and appears in the cycle after its tick item is accepted.
// Throughput: one item per cycle while out_tready is high; the output register frees as it is taken.
// The distance is kept as a running quotient, so echo fall needs no divider.
// Reset (rst_n low, synchronous): idle, counters and last distance zero,
// registers at their defaults, no result pending.
`timescale 1ns / 1ps
`include "ultrasonic_echo_ranger_top_assert.svh"
module ultrasonic_echo_ranger_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [7:0]                in_tdata,   // [0] start_req, [1] echo_level
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // [0] trigger_level, [1] busy_res, [2] done_res, [18:3] distance_cm
  output logic [23:0]               out_tdata,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [uer_pkg::IDX_W-1:0] cfg_index,
  input  logic [uer_pkg::CFG_W-1:0] cfg_data
);

  uer_pkg::dp_cmd_t            cmd;
  uer_pkg::dp_stat_t           stat;
  logic                        trig, busy, done;
  logic [uer_pkg::DIST_W-1:0]  last_dist;

  assign cfg_ready = 1'b1;
  assign out_tdata = {5'd0, last_dist, done, busy, trig};

  uer_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .start_req  (in_tdata[0]),
    .echo_level (in_tdata[1]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .trig_out   (trig),
    .busy_out   (busy),
    .done_out   (done),
    .stat       (stat),
    .cmd        (cmd)
  );

  uer_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .last_dist (last_dist)
  );

  // A start taken while idle drives the trigger on the very next result.
  `UER_ASSERT_NEXT(a_start_trig, in_tvalid && in_tready && in_tdata[0] && !busy, out_tvalid && trig)
  // A finished measurement leaves the block idle with the trigger low.
  `UER_ASSERT_NOW(a_done_idle, out_tvalid && done, !busy && !trig)
  // The trigger is never driven on the same result as done.
  `UER_ASSERT_NOW(a_trig_busy, out_tvalid && trig, !done)

endmodule
